// File: design/mwt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_pkg
// Shared constants and types of the morphological window transform: window
// geometry, field widths and the link record passed from cell to cell.
// ----------------------------------------------------------------------------
package mwt_pkg;

  // Window geometry: center sits HALF_WIDTH samples back
  localparam int HALF_WIDTH = 4;
  localparam int WIN_LEN    = 2 * HALF_WIDTH + 1;

  // Field widths
  localparam int SAMPLE_W = 12;
  localparam int OUT_W    = 17;
  localparam int SUM_W    = SAMPLE_W + 3;
  localparam int PROD_W   = SUM_W + 4;
  localparam int SCALE    = 10;

  // Sweep counter must hold WIN_LEN itself
  localparam int CNT_W = $clog2(WIN_LEN + 1);

  // Stream widths, padded to whole bytes
  localparam int S_DATA_W = ((SAMPLE_W + 7) / 8) * 8;
  localparam int M_DATA_W = ((OUT_W + 7) / 8) * 8;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // Data handed from one cell to the next
  typedef struct packed {
    sample_t sample;  // sample shifted along the delay line
    sample_t hi;      // running window maximum (never below zero)
    sample_t lo;      // running window minimum (never above zero)
  } link_t;

endpackage

// File: design/mwt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_cell
// One tap of the delay line. Holds a sample, shifts it on to its neighbor on
// an accepted beat and folds it into the running max/min every cycle.
// ----------------------------------------------------------------------------
module mwt_cell
  import mwt_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  link_t link_in,
  output link_t link_out
);

  sample_t sample;
  sample_t hi;
  sample_t lo;

  // Advance the delay line; reset fills it with zeros
  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (shift) begin
      sample <= link_in.sample;
    end
  end

  // Fold this tap into the max/min travelling down the chain
  always_ff @(posedge clk) begin
    hi <= (sample > link_in.hi) ? sample : link_in.hi;
    lo <= (sample < link_in.lo) ? sample : link_in.lo;
  end

  assign link_out.sample = sample;
  assign link_out.hi     = hi;
  assign link_out.lo     = lo;

endmodule

// File: design/morphological_window_transform.sv
`timescale 1ns / 1ps
// One sample at a time: the input closes on an accepted beat while the max/min
// fold ripples through the nine-cell chain one cell per cycle; the result then
// loads into the output register once that register is free, and the input
// reopens in the cycle after that load.
// Reset: rst is synchronous, active high; it clears the delay line to zeros
// and drops any pending result.
// ----------------------------------------------------------------------------
// morphological_window_transform
// Delay line of 2*HALF_WIDTH+1 cells with a running max/min. Each beat yields
// (max + min - 2*center) * 10 / HALF_WIDTH, truncated toward zero.
// ----------------------------------------------------------------------------
module morphological_window_transform
  import mwt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,   // [11:0] sample_in
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata    // [16:0] transform_value
);

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_SWEEP = 1'b1;

  logic                     state;
  logic [CNT_W-1:0]         cnt;
  logic                     shift;
  logic                     sweep_done;
  logic                     load;
  link_t                    links [0:WIN_LEN];
  logic signed [SUM_W-1:0]  sum;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] quot;
  logic signed [OUT_W-1:0]  result;

  assign s_tready   = (state == ST_IDLE);
  assign shift      = s_tvalid && s_tready;
  assign sweep_done = (state == ST_SWEEP) && (cnt == CNT_W'(WIN_LEN));
  assign load       = sweep_done && (!m_tvalid || m_tready);

  // Head of the chain: new sample, zero max/min seeds
  assign links[0].sample = sample_t'(s_tdata[SAMPLE_W-1:0]);
  assign links[0].hi     = '0;
  assign links[0].lo     = '0;

  // Row of cells
  for (genvar k = 0; k < WIN_LEN; k++) begin : g_cell
    mwt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .link_in  (links[k]),
      .link_out (links[k+1])
    );
  end

  // Sequence: take a beat, wait for the fold to settle, hand off the result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (shift) begin
            state <= ST_SWEEP;
            cnt   <= '0;
          end
        end
        ST_SWEEP: begin
          if (cnt != CNT_W'(WIN_LEN)) begin
            cnt <= cnt + 1'b1;
          end else if (load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Transform at the center tap
  always_comb begin
    sum  = SUM_W'(links[WIN_LEN].hi) + SUM_W'(links[WIN_LEN].lo)
         - (SUM_W'(links[HALF_WIDTH+1].sample) <<< 1);
    prod = PROD_W'(sum) * PROD_W'(SCALE);
    quot = prod / PROD_W'(HALF_WIDTH);
  end

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= OUT_W'(quot);
    end
  end

  assign m_tdata = {{(M_DATA_W - OUT_W){1'b0}}, result};

endmodule

// File: design/mwt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwt_checker
// Port-level checks of the morphological window transform, bound to the top.
// ----------------------------------------------------------------------------
module mwt_checker
  import mwt_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic [S_DATA_W-1:0] s_tdata,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata
);

  logic signed [OUT_W-1:0] out_val;
  assign out_val = m_tdata[OUT_W-1:0];

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // One sample at a time: no beat right after an accepted beat
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while previous sample in flight");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

  // Result stays within a bound that covers every reachable value, padding zero
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_val >= -61430) && (out_val <= 61430)
                  && (m_tdata[M_DATA_W-1:OUT_W] == '0)))
    else $error("result out of range");

endmodule

bind morphological_window_transform mwt_checker u_mwt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
